### rtl/crc16_packet_framer_checker_defines.svh
// assertion macros for the crc16 packet framer and checker
`ifndef CRC16_PACKET_FRAMER_CHECKER_DEFINES_SVH
`define CRC16_PACKET_FRAMER_CHECKER_DEFINES_SVH

`ifndef SYNTHESIS
`define CPFC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CPFC_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CPFC_ASSERT(label, prop, msg)
`define CPFC_ASSERT_RST(label, prop, msg)
`endif

`endif

### rtl/cpfc_pkg.sv
// shared types, codes and crc function for the crc16 packet framer and checker
`default_nettype none

package cpfc_pkg;

  localparam logic [15:0] CrcPoly = 16'h1021;
  localparam logic [15:0] CrcTop  = 16'h8000;

  localparam logic [1:0] KindTx     = 2'd0;
  localparam logic [1:0] KindRx     = 2'd1;
  localparam logic [1:0] KindStatus = 2'd2;

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StBad   = 2'd1;
  localparam logic [1:0] StShort = 2'd2;

  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);
  localparam int MaxRes = 3;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] out_kind;
    logic [1:0] status;
    logic       run_last;
  } result_t;

  typedef struct packed {
    logic [1:0]              n;
    result_t [MaxRes-1:0]    res;
  } push_t;

  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((c & CrcTop) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/cpfc_engine.sv
// input register, crc state and per-word result generation
`default_nettype none

`include "crc16_packet_framer_checker_defines.svh"

module cpfc_engine (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output      logic                      in_ready,
  input  wire logic                      command,
  input  wire logic [7:0]                data_byte,
  input  wire logic                      first,
  input  wire logic                      last,
  input  wire logic                      crc_on,
  input  wire logic [cpfc_pkg::QCntW-1:0] free,
  output      cpfc_pkg::push_t           push
);

  logic        iv;
  logic        r_cmd;
  logic [7:0]  r_byte;
  logic        r_first;
  logic        r_last;
  logic        r_crc_on;

  logic [15:0] crc;
  logic [15:0] crc_next;
  logic [7:0]  hb0;
  logic [7:0]  hb0_next;
  logic [7:0]  hb1;
  logic [7:0]  hb1_next;
  logic [1:0]  fill;
  logic [1:0]  fill_next;

  logic [15:0] tx_crc;
  logic [15:0] rx_crc;
  logic        full;
  logic        proc;
  logic        accept;
  logic [1:0]  n;
  logic [1:0]  st;
  cpfc_pkg::result_t [cpfc_pkg::MaxRes-1:0] res;

  assign full   = fill[1];
  assign tx_crc = cpfc_pkg::crc_fold(r_first ? 16'h0000 : crc, r_byte);
  assign rx_crc = cpfc_pkg::crc_fold(crc, hb0);

  always_comb begin
    crc_next  = crc;
    hb0_next  = hb0;
    hb1_next  = hb1;
    fill_next = fill;
    n         = 2'd0;
    st        = cpfc_pkg::StOk;
    res       = '0;
    if (!r_cmd) begin
      crc_next = tx_crc;
      if (r_first) begin
        fill_next = 2'd0;
      end
      res[0] = '{r_byte, cpfc_pkg::KindTx, cpfc_pkg::StOk, !(r_last && r_crc_on)};
      n = 2'd1;
      if (r_last && r_crc_on) begin
        res[1] = '{tx_crc[15:8], cpfc_pkg::KindTx, cpfc_pkg::StOk, 1'b0};
        res[2] = '{tx_crc[7:0], cpfc_pkg::KindTx, cpfc_pkg::StOk, 1'b1};
        n = 2'd3;
      end
    end else if (!r_crc_on) begin
      res[0] = '{r_byte, cpfc_pkg::KindRx, cpfc_pkg::StOk, 1'b1};
      n = 2'd1;
    end else begin
      if (full) begin
        crc_next = rx_crc;
        res[0]   = '{hb0, cpfc_pkg::KindRx, cpfc_pkg::StOk, !r_last};
        n        = 2'd1;
        hb0_next = hb1;
        hb1_next = r_byte;
      end else begin
        if (fill[0]) begin
          hb1_next = r_byte;
        end else begin
          hb0_next = r_byte;
        end
        fill_next = fill + 2'd1;
      end
      if (r_last) begin
        if (full || fill[0]) begin
          st = ({hb0_next, hb1_next} == crc_next) ? cpfc_pkg::StOk : cpfc_pkg::StBad;
        end else begin
          st = cpfc_pkg::StShort;
        end
        if (full) begin
          res[1] = '{8'h00, cpfc_pkg::KindStatus, st, 1'b1};
          n = 2'd2;
        end else begin
          res[0] = '{8'h00, cpfc_pkg::KindStatus, st, 1'b1};
          n = 2'd1;
        end
        fill_next = 2'd0;
      end
    end
  end

  assign proc     = iv && ({{(cpfc_pkg::QCntW-2){1'b0}}, n} <= free);
  assign in_ready = !iv || proc;
  assign accept   = in_valid && in_ready;
  assign push.n   = proc ? n : 2'd0;
  assign push.res = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      iv   <= 1'b0;
      crc  <= 16'h0000;
      hb0  <= 8'h00;
      hb1  <= 8'h00;
      fill <= 2'd0;
    end else begin
      if (accept) begin
        iv <= 1'b1;
      end else if (proc) begin
        iv <= 1'b0;
      end
      if (proc) begin
        crc  <= crc_next;
        hb0  <= hb0_next;
        hb1  <= hb1_next;
        fill <= fill_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      r_cmd    <= command;
      r_byte   <= data_byte;
      r_first  <= first;
      r_last   <= last;
      r_crc_on <= crc_on;
    end
  end

  `CPFC_ASSERT(a_fill_range, fill != 2'd3, "holdback fill out of range")
  `CPFC_ASSERT(a_push_fits, proc |-> ({{(cpfc_pkg::QCntW-2){1'b0}}, push.n} <= free), "push overflows queue")

endmodule

`default_nettype wire

### rtl/cpfc_outq.sv
// result queue taking up to three results per cycle and giving one per cycle while out_ready is high
`default_nettype none

`include "crc16_packet_framer_checker_defines.svh"

module cpfc_outq (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire cpfc_pkg::push_t            push,
  output      logic [cpfc_pkg::QCntW-1:0] free,
  output      logic                       out_valid,
  input  wire logic                       out_ready,
  output      cpfc_pkg::result_t          head
);

  cpfc_pkg::result_t mem [cpfc_pkg::QDepth];
  logic [cpfc_pkg::QPtrW-1:0] wr;
  logic [cpfc_pkg::QPtrW-1:0] rd;
  logic [cpfc_pkg::QCntW-1:0] count;
  logic [cpfc_pkg::QCntW-1:0] count_next;
  logic                       pop;

  assign out_valid  = count != '0;
  assign pop        = out_valid && out_ready;
  assign head       = mem[rd];
  assign free       = cpfc_pkg::QCntW'(cpfc_pkg::QDepth) - count
                      + {{(cpfc_pkg::QCntW-1){1'b0}}, pop};
  assign count_next = count + {{(cpfc_pkg::QCntW-2){1'b0}}, push.n}
                      - {{(cpfc_pkg::QCntW-1){1'b0}}, pop};

  always_ff @(posedge clk) begin
    if (rst) begin
      wr    <= '0;
      rd    <= '0;
      count <= '0;
    end else begin
      wr    <= wr + cpfc_pkg::QPtrW'(push.n);
      rd    <= rd + {{(cpfc_pkg::QPtrW-1){1'b0}}, pop};
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < cpfc_pkg::MaxRes; i++) begin
      if (i < int'(push.n)) begin
        mem[wr + cpfc_pkg::QPtrW'(i)] <= push.res[i];
      end
    end
  end

  `CPFC_ASSERT(a_count_bound, count <= cpfc_pkg::QCntW'(cpfc_pkg::QDepth), "queue count overflow")
  `CPFC_ASSERT_RST(a_reset_empty, rst |=> (count == '0), "queue not empty after reset")

endmodule

`default_nettype wire

### rtl/crc16_packet_framer_checker.sv
// top level of the crc16 packet framer and checker
`default_nettype none

// Framer and checker for a byte stream protected by CRC-16 (poly 0x1021, init 0,
// msb first). A transmit word is echoed and folded into the running crc; with
// last and crc_on the two crc bytes follow, high byte first. Received words
// with crc_on pass through a two-byte holdback window, and last gives a status
// word (ok, mismatch, too short). A word is taken into an input register and
// turned into its zero to three results through unrolled crc logic; these go
// into a four-entry result queue once it has room for them. Input words are
// accepted every cycle while the queue has room for the results; sustained rate
// is one input word per cycle, limited by the output side at one result per
// cycle while out_ready is high; a crc-appending transmit word gives three.
module crc16_packet_framer_checker (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output      logic       in_ready,
  input  wire logic       command,
  input  wire logic [7:0] data_byte,
  input  wire logic       first,
  input  wire logic       last,
  input  wire logic       crc_on,
  output      logic       out_valid,
  input  wire logic       out_ready,
  output      logic [7:0] out_byte,
  output      logic [1:0] out_kind,
  output      logic [1:0] status,
  output      logic       run_last
);

  cpfc_pkg::push_t            push;
  cpfc_pkg::result_t          head;
  logic [cpfc_pkg::QCntW-1:0] free;

  cpfc_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (command),
    .data_byte (data_byte),
    .first     (first),
    .last      (last),
    .crc_on    (crc_on),
    .free      (free),
    .push      (push)
  );

  cpfc_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .free      (free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign out_byte = head.out_byte;
  assign out_kind = head.out_kind;
  assign status   = head.status;
  assign run_last = head.run_last;

endmodule

`default_nettype wire
